// ===== rtl/xpd_pkg.sv =====
package xpd_pkg;

  // item kinds on the input stream
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_ROW_END = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_WRITTEN     = 2'd0,
    ST_TRANSPARENT = 2'd1,
    ST_NO_MATCH    = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_CHARS_PER_PIXEL = 3'd0,
    CFG_COLOR_COUNT     = 3'd1,
    CFG_IMAGE_WIDTH     = 3'd2,
    CFG_IMAGE_HEIGHT    = 3'd3,
    CFG_WIDE_PIXELS     = 3'd4
  } cfg_index_e;

  localparam int unsigned KeyBytes  = 7;
  localparam int unsigned KeyW      = 8 * KeyBytes;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned InDataW   = 112;
  localparam int unsigned OutDataW  = 56;
  localparam logic [PixelW-1:0] NarrowMask = 32'h0000_ffff;

  // token that walks down the palette cells: either a palette load
  // or a pixel key lookup collecting its first match on the way
  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic              found;
    logic [7:0]        index;
    logic [KeyW-1:0]   key;
    logic [PixelW-1:0] pixel;
    logic              transp;
    logic [2:0]        cpp;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } token_t;

endpackage

// ===== rtl/xpd_cell.sv =====
module xpd_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic [8:0]      color_count_i,
  input  xpd_pkg::token_t tok_i,
  output xpd_pkg::token_t tok_o
);
  import xpd_pkg::*;

  logic [KeyW-1:0]   key_q;
  logic [PixelW-1:0] pix_q;
  logic              tr_q;
  token_t            tok_d;
  token_t            tok_q;
  logic              slot_hit;
  logic              active;
  logic              key_eq;

  assign slot_hit = tok_i.valid && tok_i.is_load && (32'(tok_i.index) == IDX);
  assign active   = IDX < 32'(color_count_i);

  // masked key compare, byte by byte over the current key size
  always_comb begin
    key_eq = 1'b1;
    for (int b = 0; b < KeyBytes; b++) begin
      if ((3'(b) < tok_i.cpp) && (key_q[8*b +: 8] != tok_i.key[8*b +: 8])) begin
        key_eq = 1'b0;
      end
    end
  end

  // first match along the chain claims the lookup
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.is_load && !tok_i.found && active && key_eq) begin
      tok_d.found  = 1'b1;
      tok_d.pixel  = pix_q;
      tok_d.transp = tr_q;
    end
  end

  // palette entry storage
  always_ff @(posedge clk_i) begin
    if (adv_i && slot_hit) begin
      key_q <= tok_i.key;
      pix_q <= tok_i.pixel;
      tr_q  <= tok_i.transp;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/xpd_front.sv =====
module xpd_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        take_i,
  input  xpd_pkg::kind_e              kind_i,
  input  logic [7:0]                  entry_index_i,
  input  logic [xpd_pkg::KeyW-1:0]    entry_key_i,
  input  logic [xpd_pkg::PixelW-1:0]  entry_pixel_i,
  input  logic                        entry_transparent_i,
  input  logic [7:0]                  char_code_i,
  input  logic [2:0]                  cpp_i,
  input  logic [12:0]                 width_i,
  input  logic [12:0]                 height_i,
  output xpd_pkg::token_t             tok_o
);
  import xpd_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned EW = (DW > 13) ? DW : 13;

  logic [KeyW-1:0] gather_q, gather_d, key_new;
  logic [2:0]      cnt_q, cnt_d;
  logic [3:0]      cnt_new;
  logic [DW-1:0]   col_q, col_d, row_q, row_d;
  logic [EW-1:0]   width_eff, height_eff;
  logic [2:0]      cpp_eff;
  logic            in_image;
  token_t          tok_d, tok_q;

  // clamp image size to the supported maximum
  always_comb begin
    width_eff  = EW'(width_i);
    height_eff = EW'(height_i);
    if (width_eff > EW'(MAX_DIM)) begin
      width_eff = EW'(MAX_DIM);
    end
    if (height_eff > EW'(MAX_DIM)) begin
      height_eff = EW'(MAX_DIM);
    end
  end

  assign cpp_eff  = (cpp_i == 3'd0) ? 3'd1 : cpp_i;
  assign in_image = (EW'(row_q) < height_eff) && (EW'(col_q) < width_eff);
  assign cnt_new  = {1'b0, cnt_q} + 4'd1;

  // place the new character at the next byte of the key
  always_comb begin
    key_new = gather_q;
    for (int b = 0; b < KeyBytes; b++) begin
      if (cnt_q == 3'(b)) begin
        key_new[8*b +: 8] = gather_q[8*b +: 8] | char_code_i;
      end
    end
  end

  // item decode and key gathering
  always_comb begin
    gather_d = gather_q;
    cnt_d    = cnt_q;
    col_d    = col_q;
    row_d    = row_q;
    tok_d    = '0;
    if (take_i) begin
      case (kind_i)
        KIND_LOAD: begin
          tok_d.valid   = 1'b1;
          tok_d.is_load = 1'b1;
          tok_d.index   = entry_index_i;
          tok_d.key     = entry_key_i;
          tok_d.pixel   = entry_pixel_i;
          tok_d.transp  = entry_transparent_i;
        end
        KIND_ROW_END: begin
          gather_d = '0;
          cnt_d    = '0;
          col_d    = '0;
          if (EW'(row_q) < height_eff) begin
            row_d = row_q + 1'b1;
          end
        end
        KIND_PIXEL: begin
          if (in_image) begin
            if (cnt_new >= {1'b0, cpp_eff}) begin
              tok_d.valid  = 1'b1;
              tok_d.key    = key_new;
              tok_d.cpp    = cpp_eff;
              tok_d.column = CoordW'(col_q);
              tok_d.row    = CoordW'(row_q);
              gather_d     = '0;
              cnt_d        = '0;
              col_d        = col_q + 1'b1;
            end else begin
              gather_d = key_new;
              cnt_d    = cnt_new[2:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // gather state and position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q <= '0;
      cnt_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      gather_q <= gather_d;
      cnt_q    <= cnt_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // token launch into the cell chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/xpm_palette_pixel_decoder.sv =====
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: entry_index, entry_key, entry_pixel,
//                                        entry_transparent, char_code; tuser: kind
// m_axis    out  m_axis_tvalid/tready    tdata: column, row, pixel_value; tuser: status
// cfg       in   cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// one input word is taken every cycle while the output is not stalled
// a pixel result leaves through the front token register, every palette cell register
// and the output register, the path a lookup takes to walk the row of palette cells
// palette loads walk the same row, so lookups always see earlier loads
// an output word that is held back freezes the whole chain and input
// reset clears the gather state, counters and tokens and sets the config registers to defaults
module xpm_palette_pixel_decoder #(
  parameter int unsigned MAX_COLORS = 256,
  parameter int unsigned MAX_DIM    = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // entry_index, entry_key, entry_pixel, entry_transparent, char_code, pad
  input  logic [xpd_pkg::InDataW-1:0]   s_axis_tdata,
  // kind
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // column, row, pixel_value
  output logic [xpd_pkg::OutDataW-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_addr_i,
  input  logic [xpd_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import xpd_pkg::*;

  logic [2:0]          cpp_q;
  logic [8:0]          color_count_q;
  logic [12:0]         width_q;
  logic [12:0]         height_q;
  logic                wide_q;
  logic                adv;
  logic                take;
  token_t              chain [MAX_COLORS+1];
  token_t              last;
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [1:0]          m_user_q;
  status_e             status;
  logic [PixelW-1:0]   pixel;

  // chain moves whenever the output register can take a word
  assign adv           = !m_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_q         <= 3'd1;
      color_count_q <= 9'd0;
      width_q       <= 13'd16;
      height_q      <= 13'd16;
      wide_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_addr_i))
        CFG_CHARS_PER_PIXEL: cpp_q         <= cfg_wdata_i[2:0];
        CFG_COLOR_COUNT:     color_count_q <= cfg_wdata_i[8:0];
        CFG_IMAGE_WIDTH:     width_q       <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:    height_q      <= cfg_wdata_i;
        CFG_WIDE_PIXELS:     wide_q        <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // key gathering and token launch
  xpd_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .adv_i              (adv),
    .take_i             (take),
    .kind_i             (kind_e'(s_axis_tuser)),
    .entry_index_i      (s_axis_tdata[7:0]),
    .entry_key_i        (s_axis_tdata[63:8]),
    .entry_pixel_i      (s_axis_tdata[95:64]),
    .entry_transparent_i(s_axis_tdata[96]),
    .char_code_i        (s_axis_tdata[104:97]),
    .cpp_i              (cpp_q),
    .width_i            (width_q),
    .height_i           (height_q),
    .tok_o              (chain[0])
  );

  // row of palette cells, one entry each
  for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
    xpd_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .color_count_i(color_count_q),
      .tok_i        (chain[i]),
      .tok_o        (chain[i+1])
    );
  end

  assign last = chain[MAX_COLORS];

  // result formatting
  always_comb begin
    status = ST_NO_MATCH;
    pixel  = '0;
    if (last.found) begin
      if (last.transp) begin
        status = ST_TRANSPARENT;
      end else begin
        status = ST_WRITTEN;
        pixel  = wide_q ? last.pixel : (last.pixel & NarrowMask);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= last.valid && !last.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {pixel, last.row, last.column};
      m_user_q <= status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/xpd_checker.sv =====
module xpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic [xpd_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);
  import xpd_pkg::*;

  // a held output word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // input stalls only behind a stalled output word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // status code is always a defined one
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_WRITTEN) || (m_axis_tuser == ST_TRANSPARENT) ||
                      (m_axis_tuser == ST_NO_MATCH))
    else $error("undefined status code");

  // skipped pixels carry a zero value
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_WRITTEN) |-> m_axis_tdata[55:24] == '0)
    else $error("nonzero pixel on a skipped result");

endmodule

bind xpm_palette_pixel_decoder xpd_checker u_xpd_checker (.*);
